// ===== sv/als_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_pkg: shared types and constants of the ascending list sorter
// Holds the control word that steers every cell of the sorting chain and
// the fixed width of the result word.
// ----------------------------------------------------------------------------
package als_pkg;

   // width of the value field on both channels
   localparam int OUT_BITS = 32;

   // per-cycle command broadcast to all cells of the chain
   typedef struct packed {
      logic insert;   // place the incoming word in sorted position
      logic shift;    // move every word one cell towards the head
   } cell_ctrl_type;

endpackage

// ===== sv/als_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// als_cell: one cell of the insertion sorting chain
// Holds one word and its occupancy bit. On insert it keeps its word, takes
// the new word or takes its left neighbour's word; on shift it takes its
// right neighbour's word.
// ----------------------------------------------------------------------------
module als_cell
   import als_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cell_ctrl_type                ctrl,
   input  logic signed [VALUE_BITS-1:0] new_value,
   input  logic                         left_valid,
   input  logic signed [VALUE_BITS-1:0] left_value,
   input  logic                         left_keep,
   input  logic                         right_valid,
   input  logic signed [VALUE_BITS-1:0] right_value,
   output logic                         valid,
   output logic signed [VALUE_BITS-1:0] value,
   output logic                         keep
);

   logic                         valid_ff, valid_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;

   // an occupied cell not greater than the new word stays put (equal words
   // stay ahead of the new one, so arrival order is kept)
   assign keep = valid_ff && !(value_ff > new_value);

   // next cell contents, idle cycles hold the cell
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.shift) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (ctrl.insert && !keep) begin
         if (left_keep) begin
            valid_in = 1'b1;
            value_in = new_value;
         end else begin
            valid_in = left_valid;
            value_in = left_value;
         end
      end
   end

   // occupancy bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stored word
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;

endmodule

// ===== sv/ascending_list_sorter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_list_sorter_unit: sorts a list of signed words in ascending order
// Words arrive on the req_ channel, the final one flagged by req_last. Each
// accepted word drops straight into its sorted place in a chain of CAPACITY
// cells, so words can be loaded back to back while req_stall is low. Words that
// arrive while all cells are full are dropped and the list is marked as
// overflowed.
// In the cycle after the final word is accepted the head cell presents the
// smallest word on the rsp_ channel; each accepted result shifts the chain
// one cell towards the head, so results stream out at one per cycle while
// rsp_stall is low. rsp_last_res flags the largest word, rsp_overflow is set
// on every result of a list that lost words. Equal words leave in arrival
// order. While results are being delivered req_stall is high, so the next
// list is held off until the final result of this one is taken. A stall on
// rsp_ freezes the chain and the presented word.
// Reset empties the chain and clears the overflow mark; the stored words
// themselves are not cleared.
// ----------------------------------------------------------------------------
module ascending_list_sorter_unit
   import als_pkg::*;
#(
   parameter int CAPACITY   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [OUT_BITS-1:0] req_value,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OUT_BITS-1:0] rsp_value_res,
   output logic                       rsp_last_res,
   output logic                       rsp_overflow
);

   logic                         drain_ff, drain_in;
   logic                         overflow_ff, overflow_in;
   logic                         in_take, out_take, full;
   logic signed [VALUE_BITS-1:0] new_value;
   cell_ctrl_type                ctrl;
   logic                         cell_valid [CAPACITY];
   logic signed [VALUE_BITS-1:0] cell_value [CAPACITY];
   logic                         cell_keep  [CAPACITY];

   // handshakes
   assign in_take  = req_valid && !drain_ff;
   assign out_take = rsp_valid && !rsp_stall;
   assign full     = cell_valid[CAPACITY-1];

   assign ctrl.insert = in_take && !full;
   assign ctrl.shift  = out_take;

   // incoming word resized to the stored width
   generate
      if (VALUE_BITS >= OUT_BITS) begin : g_in_wide
         assign new_value = VALUE_BITS'(req_value);
      end else begin : g_in_narrow
         assign new_value = req_value[VALUE_BITS-1:0];
      end
   endgenerate

   // chain of cells, head at index 0
   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic                         l_valid, l_keep, r_valid;
         logic signed [VALUE_BITS-1:0] l_value, r_value;

         if (i == 0) begin : g_head
            assign l_valid = 1'b0;
            assign l_value = '0;
            assign l_keep  = 1'b1;
         end else begin : g_body
            assign l_valid = cell_valid[i-1];
            assign l_value = cell_value[i-1];
            assign l_keep  = cell_keep[i-1];
         end

         if (i == CAPACITY - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_value = '0;
         end else begin : g_inner
            assign r_valid = cell_valid[i+1];
            assign r_value = cell_value[i+1];
         end

         als_cell #(
            .VALUE_BITS (VALUE_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_value   (new_value),
            .left_valid  (l_valid),
            .left_value  (l_value),
            .left_keep   (l_keep),
            .right_valid (r_valid),
            .right_value (r_value),
            .valid       (cell_valid[i]),
            .value       (cell_value[i]),
            .keep        (cell_keep[i])
         );
      end
   endgenerate

   // load / drain control and overflow mark
   always_comb begin
      drain_in    = drain_ff;
      overflow_in = overflow_ff;
      if (in_take && full) begin
         overflow_in = 1'b1;
      end
      if (in_take && req_last) begin
         drain_in = 1'b1;
      end
      if (out_take && rsp_last_res) begin
         drain_in    = 1'b0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff    <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         drain_ff    <= drain_in;
         overflow_ff <= overflow_in;
      end
   end

   // result word straight from the head cell
   generate
      if (VALUE_BITS >= OUT_BITS) begin : g_out_wide
         assign rsp_value_res = cell_value[0][OUT_BITS-1:0];
      end else begin : g_out_narrow
         assign rsp_value_res = OUT_BITS'(cell_value[0]);
      end
   endgenerate

   assign req_stall    = drain_ff;
   assign rsp_valid    = drain_ff;
   assign rsp_last_res = !cell_valid[1];
   assign rsp_overflow = overflow_ff;

   // head cell always holds a word while results are offered
   a_head_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cell_valid[0])
      else $error("result offered from an empty chain");

   // results leave in non-decreasing order
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (out_take && !rsp_last_res) |=> !($past(cell_value[0]) > cell_value[0]))
      else $error("results out of order");

   // final result leaves the chain empty and ready for loading
   a_empty_after: assert property (@(posedge clock) disable iff (reset)
      (out_take && rsp_last_res) |=> (!cell_valid[0] && !rsp_valid && !rsp_overflow))
      else $error("chain not empty after final result");

endmodule
